[hdl/ddpds_pkg.sv]
`timescale 1ns / 1ps

package ddpds_pkg;

    // Default number of fraction bits in every fixed-point quantity.
    localparam int FRAC_BITS_DEF = 8;

    // Speed bytes: mid-scale stop value and full-scale top.
    localparam int SPEED_MID = 128;
    localparam int SPEED_MAX = 255;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_DERIV_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_GAIN       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_DERIV_GAIN = 2'd3;

    typedef struct packed {
        logic signed [15:0] linear_error;
        logic signed [15:0] angular_error;
        logic        [15:0] time_step;
    } t_in_item;

    typedef struct packed {
        logic [7:0] left_speed;
        logic [7:0] right_speed;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV_LOAD,
        ST_DIV,
        ST_SIGN,
        ST_UPD,
        ST_OUT
    } t_state;

    // Which product term the sequencer is working on.
    typedef enum logic [1:0] {
        TERM_PL,
        TERM_PA,
        TERM_DL,
        TERM_DA
    } t_term;

endpackage

[hdl/differential_drive_pd_speed.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// --------  ---------  ------------------  ------------------------------------------
// input     in         i_valid / o_ready   i_in  : linear_error, angular_error, time_step
// output    out        o_valid / i_ready   o_out : left_speed, right_speed
// config    in         i_cfg_we            i_cfg_index, i_cfg_data (no wait, no read-back)
//
// An input transaction keeps the block busy until its result is in the output register; the work
// is set by the restoring divider, which retires one quotient bit a cycle and runs once per error
// channel when derivative terms are applied, and by the single shared multiplier, which forms the
// gain products one after another (two without derivative terms, four with them).
// Reset is synchronous and active low; it restores the gains to zero, both speed
// accumulators to mid-scale and clears the primed flag.
// A result waits in the output register while a new input transaction is taken; the
// sequencer only holds in its final state when that register is still occupied.

module differential_drive_pd_speed
    import ddpds_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    // Accumulators hold 0..255 with FRAC_BITS fraction bits.
    localparam int ACC_W  = 8 + FRAC_BITS;
    // Quotient of |diff| * 2^F by the time step, unsigned, and its signed form.
    localparam int QUO_W  = 16 + FRAC_BITS;
    localparam int DER_W  = QUO_W + 1;
    localparam int PROD_W = DER_W + 16;
    // Four products summed exactly need two more bits.
    localparam int SUM_W  = PROD_W + 2;
    localparam int DIV_N  = QUO_W;
    localparam int CNT_W  = $clog2(DIV_N);

    localparam logic [ACC_W-1:0] ACC_RESET = ACC_W'(SPEED_MID) << FRAC_BITS;
    localparam logic [ACC_W-1:0] ACC_TOP   = ACC_W'(SPEED_MAX) << FRAC_BITS;

    // Control state.
    t_state                    r_state,      n_state;
    t_term                     r_term,       n_term;
    logic                      r_side,       n_side;
    logic [CNT_W-1:0]          r_cnt,        n_cnt;
    logic                      r_out_valid,  n_out_valid;
    logic                      r_primed,     n_primed;
    logic [ACC_W-1:0]          r_left,       n_left;
    logic [ACC_W-1:0]          r_right,      n_right;
    logic signed [15:0]        r_prev_l,     n_prev_l;
    logic signed [15:0]        r_prev_a,     n_prev_a;
    logic signed [15:0]        r_kl,         n_kl;
    logic signed [15:0]        r_kld,        n_kld;
    logic signed [15:0]        r_ka,         n_ka;
    logic signed [15:0]        r_kad,        n_kad;

    // Payload and datapath registers.
    logic signed [15:0]        r_el,         n_el;
    logic signed [15:0]        r_ea,         n_ea;
    logic [15:0]               r_dt,         n_dt;
    logic signed [16:0]        r_diff_l,     n_diff_l;
    logic signed [16:0]        r_diff_a,     n_diff_a;
    logic                      r_use_der,    n_use_der;
    logic signed [PROD_W-1:0]  r_prod,       n_prod;
    logic signed [SUM_W-1:0]   r_sum_l,      n_sum_l;
    logic signed [SUM_W-1:0]   r_sum_r,      n_sum_r;
    logic [15:0]               r_rem,        n_rem;
    logic [QUO_W-1:0]          r_quo,        n_quo;
    logic                      r_neg,        n_neg;
    logic signed [DER_W-1:0]   r_der,        n_der;
    t_out_item                 r_out,        n_out;

    // Shared-unit operands and intermediate values.
    logic signed [DER_W-1:0]   mul_a;
    logic signed [15:0]        mul_b;
    logic signed [SUM_W-1:0]   prod_ext;
    logic [16:0]               rem_sh;
    logic                      div_ge;
    logic [16:0]               rem_sub;
    logic signed [16:0]        div_diff;
    logic signed [16:0]        div_mag;
    logic signed [SUM_W-1:0]   upd_sum;
    logic signed [SUM_W-1:0]   upd_shift;
    logic [ACC_W-1:0]          upd_acc;
    logic signed [SUM_W:0]     upd_new;
    logic [ACC_W-1:0]          upd_clamped;

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // Multiplier operand selection by term.
    always_comb begin
        case (r_term)
            TERM_PL: begin
                mul_a = DER_W'(r_el);
                mul_b = r_kl;
            end
            TERM_PA: begin
                mul_a = DER_W'(r_ea);
                mul_b = r_ka;
            end
            TERM_DL: begin
                mul_a = r_der;
                mul_b = r_kld;
            end
            TERM_DA: begin
                mul_a = r_der;
                mul_b = r_kad;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_ext = SUM_W'(r_prod);

    // One restoring divider step: shift in the next dividend bit and try the divisor.
    assign rem_sh  = {r_rem, r_quo[QUO_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_dt});
    assign rem_sub = rem_sh - {1'b0, r_dt};

    // The divider works on the magnitude of the error difference.
    assign div_diff = (r_term == TERM_DA) ? r_diff_a : r_diff_l;
    assign div_mag  = div_diff[16] ? -div_diff : div_diff;

    // Shared accumulator update: floor shift, add and clamp to the speed range.
    assign upd_sum   = r_side ? r_sum_r : r_sum_l;
    assign upd_acc   = r_side ? r_right : r_left;
    assign upd_shift = upd_sum >>> FRAC_BITS;
    assign upd_new   = (SUM_W+1)'(upd_shift)
                     + $signed({{(SUM_W+1-ACC_W){1'b0}}, upd_acc});

    always_comb begin
        if (upd_new < 0) begin
            upd_clamped = '0;
        end else if (upd_new > $signed({{(SUM_W+1-ACC_W){1'b0}}, ACC_TOP})) begin
            upd_clamped = ACC_TOP;
        end else begin
            upd_clamped = upd_new[ACC_W-1:0];
        end
    end

    // Sequencer: next state and datapath.
    always_comb begin
        n_state     = r_state;
        n_term      = r_term;
        n_side      = r_side;
        n_cnt       = r_cnt;
        n_primed    = r_primed;
        n_left      = r_left;
        n_right     = r_right;
        n_prev_l    = r_prev_l;
        n_prev_a    = r_prev_a;
        n_kl        = r_kl;
        n_kld       = r_kld;
        n_ka        = r_ka;
        n_kad       = r_kad;
        n_el        = r_el;
        n_ea        = r_ea;
        n_dt        = r_dt;
        n_diff_l    = r_diff_l;
        n_diff_a    = r_diff_a;
        n_use_der   = r_use_der;
        n_prod      = r_prod;
        n_sum_l     = r_sum_l;
        n_sum_r     = r_sum_r;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_neg       = r_neg;
        n_der       = r_der;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;

        // The user must issue configuration writes only while the block is idle; the block does not enforce this.
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINEAR_GAIN:        n_kl  = $signed(i_cfg_data);
                CFG_LINEAR_DERIV_GAIN:  n_kld = $signed(i_cfg_data);
                CFG_ANGULAR_GAIN:       n_ka  = $signed(i_cfg_data);
                CFG_ANGULAR_DERIV_GAIN: n_kad = $signed(i_cfg_data);
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_el      = i_in.linear_error;
                    n_ea      = i_in.angular_error;
                    n_dt      = i_in.time_step;
                    n_diff_l  = 17'(i_in.linear_error) - 17'(r_prev_l);
                    n_diff_a  = 17'(i_in.angular_error) - 17'(r_prev_a);
                    // The first step and a zero time step skip the derivative terms.
                    n_use_der = r_primed && (i_in.time_step != '0);
                    n_primed  = 1'b1;
                    n_prev_l  = i_in.linear_error;
                    n_prev_a  = i_in.angular_error;
                    n_sum_l   = '0;
                    n_sum_r   = '0;
                    n_term    = TERM_PL;
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = mul_a * mul_b;
                n_state = ST_ADD;
            end
            ST_ADD: begin
                // Angular terms subtract on the left wheel and add on the right.
                if (r_term == TERM_PA || r_term == TERM_DA) begin
                    n_sum_l = r_sum_l - prod_ext;
                end else begin
                    n_sum_l = r_sum_l + prod_ext;
                end
                n_sum_r = r_sum_r + prod_ext;
                n_side  = 1'b0;
                case (r_term)
                    TERM_PL: begin
                        n_term  = TERM_PA;
                        n_state = ST_MUL;
                    end
                    TERM_PA: begin
                        if (r_use_der) begin
                            n_term  = TERM_DL;
                            n_state = ST_DIV_LOAD;
                        end else begin
                            n_state = ST_UPD;
                        end
                    end
                    TERM_DL: begin
                        n_term  = TERM_DA;
                        n_state = ST_DIV_LOAD;
                    end
                    default: begin
                        n_state = ST_UPD;
                    end
                endcase
            end
            ST_DIV_LOAD: begin
                n_neg   = div_diff[16];
                n_quo   = {div_mag[15:0], {FRAC_BITS{1'b0}}};
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = div_ge ? rem_sub[15:0] : rem_sh[15:0];
                n_quo = {r_quo[QUO_W-2:0], div_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N - 1)) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: begin
                // Sign and magnitude give truncation toward zero.
                n_der   = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
                n_state = ST_MUL;
            end
            ST_UPD: begin
                if (r_side) begin
                    n_right = upd_clamped;
                    n_state = ST_OUT;
                end else begin
                    n_left = upd_clamped;
                    n_side = 1'b1;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out.left_speed  = r_left[ACC_W-1 -: 8];
                    n_out.right_speed = r_right[ACC_W-1 -: 8];
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_term      <= TERM_PL;
            r_side      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_primed    <= 1'b0;
            r_left      <= ACC_RESET;
            r_right     <= ACC_RESET;
            r_prev_l    <= '0;
            r_prev_a    <= '0;
            r_kl        <= '0;
            r_kld       <= '0;
            r_ka        <= '0;
            r_kad       <= '0;
        end else begin
            r_state     <= n_state;
            r_term      <= n_term;
            r_side      <= n_side;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_primed    <= n_primed;
            r_left      <= n_left;
            r_right     <= n_right;
            r_prev_l    <= n_prev_l;
            r_prev_a    <= n_prev_a;
            r_kl        <= n_kl;
            r_kld       <= n_kld;
            r_ka        <= n_ka;
            r_kad       <= n_kad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_el      <= n_el;
        r_ea      <= n_ea;
        r_dt      <= n_dt;
        r_diff_l  <= n_diff_l;
        r_diff_a  <= n_diff_a;
        r_use_der <= n_use_der;
        r_prod    <= n_prod;
        r_sum_l   <= n_sum_l;
        r_sum_r   <= n_sum_r;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_neg     <= n_neg;
        r_der     <= n_der;
        r_out     <= n_out;
    end

endmodule

[hdl/ddpds_checker.sv]
`timescale 1ns / 1ps

module ddpds_checker
    import ddpds_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_in,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_out
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out))
        else $error("result changed or dropped while stalled");

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an input transaction");

    // A new result only appears after the sequencer has been busy.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result appeared without work in progress");

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready && !o_valid)
        else $error("block not idle after reset");

endmodule

bind differential_drive_pd_speed ddpds_checker u_ddpds_checker (.*);
